### design/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types and constants for the MIDI note stack pitch controller.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

    // Note stack depth and scan pointer width
    localparam int STACK_DEPTH = 8;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Bend word at rest, and offset that recentres bend_word >> 8
    localparam logic [13:0] BEND_CENTRE  = 14'd8192;
    localparam logic [7:0]  PITCH_OFFSET = 8'd32;

    // Configuration register indexes
    localparam logic [1:0] REG_MIDI_ENABLE  = 2'd0;
    localparam logic [1:0] REG_MIDI_CHANNEL = 2'd1;
    localparam logic [1:0] REG_MAX_PITCH    = 2'd2;
    localparam logic [1:0] REG_MAX_ON_TIME  = 2'd3;

    // Status nibbles and special system statuses
    localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
    localparam logic [3:0] KIND_KEY_PRESS  = 4'hA;
    localparam logic [3:0] KIND_PROG       = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESS = 4'hD;
    localparam logic [3:0] KIND_BEND       = 4'hE;
    localparam logic [7:0] SYS_SONG_SEL    = 8'hF3;
    localparam logic [7:0] SYS_UNDEF_F5    = 8'hF5;
    localparam logic [7:0] SYS_TUNE_REQ    = 8'hF6;

    // Stack operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_REMOVE,
        OP_PRESSURE,
        OP_CHAN_PRESS
    } stk_op_t;

    // Command from the parser to the stack unit
    typedef struct packed {
        logic        valid;
        stk_op_t     op;
        logic [6:0]  key;
        logic [6:0]  vel;
    } stk_cmd_t;

    // Status from the stack unit back to the parser
    typedef struct packed {
        logic        done;
        logic [6:0]  top_key;
        logic [6:0]  top_vel;
    } stk_stat_t;

endpackage

`default_nettype wire

### design/nsp_stack.sv
// ----------------------------------------------------------------------------
// nsp_stack
// Last-note-priority key/velocity stack with a single key comparator that
// walks the slots one per cycle for note off and key pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_stack
    import nsp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire stk_cmd_t  cmd,
    output stk_stat_t      stat
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(STACK_DEPTH - 1);

    state_t             state_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic               done_reg;
    logic [6:0]         slot_key_reg [STACK_DEPTH];
    logic [6:0]         slot_vel_reg [STACK_DEPTH];

    stk_op_t            req_op_reg;
    logic [6:0]         req_key_reg;
    logic [6:0]         req_vel_reg;

    logic               hit;

    // Shared comparator on the slot under the pointer
    assign hit = (slot_key_reg[ptr_reg] == req_key_reg);

    assign stat.done    = done_reg;
    assign stat.top_key = slot_key_reg[0];
    assign stat.top_vel = slot_vel_reg[0];

    // Held command fields for the scan
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && cmd.valid) begin
            req_op_reg  <= cmd.op;
            req_key_reg <= cmd.key;
            req_vel_reg <= cmd.vel;
        end
    end

    // Sequencer and slot storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
            for (int j = 0; j < STACK_DEPTH; j++) begin
                slot_key_reg[j] <= '0;
                slot_vel_reg[j] <= '0;
            end
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (cmd.valid) begin
                        ptr_reg <= '0;
                        case (cmd.op)
                            OP_PUSH: begin
                                for (int j = 1; j < STACK_DEPTH; j++) begin
                                    slot_key_reg[j] <= slot_key_reg[j-1];
                                    slot_vel_reg[j] <= slot_vel_reg[j-1];
                                end
                                slot_key_reg[0] <= cmd.key;
                                slot_vel_reg[0] <= cmd.vel;
                                done_reg <= 1'b1;
                            end
                            OP_CHAN_PRESS: begin
                                slot_vel_reg[0] <= cmd.vel;
                                done_reg <= 1'b1;
                            end
                            OP_REMOVE, OP_PRESSURE: begin
                                state_reg <= S_SCAN;
                            end
                            default: begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        if (req_op_reg == OP_REMOVE) begin
                            // close the gap from the matching slot upward
                            for (int j = 0; j < STACK_DEPTH - 1; j++) begin
                                if (PTR_W'(j) >= ptr_reg) begin
                                    slot_key_reg[j] <= slot_key_reg[j+1];
                                    slot_vel_reg[j] <= slot_vel_reg[j+1];
                                end
                            end
                            slot_key_reg[STACK_DEPTH-1] <= '0;
                            slot_vel_reg[STACK_DEPTH-1] <= '0;
                        end else begin
                            slot_vel_reg[ptr_reg] <= req_vel_reg;
                        end
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end else if (ptr_reg == LAST_PTR) begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A command only ever arrives while no scan is running
    a_cmd_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.valid |-> state_reg == S_IDLE)
        else $error("stack command during scan");

    // Completion is a single-cycle pulse
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("stack done held for more than one cycle");
`endif

endmodule

`default_nettype wire

### design/midi_note_stack_pitch_control.sv
// ----------------------------------------------------------------------------
// midi_note_stack_pitch_control
// MIDI byte parser with running status, last-note-priority note stack and
// 14-bit pitch bend; emits a clamped pitch index and on-time index.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  s_       s_valid / s_ready    s_midi_byte[7:0]
//  m_       m_valid / m_ready    m_pitch_index[7:0], m_on_time_index[6:0]
//  cfg_     cfg_wen              cfg_index[1:0], cfg_wdata[7:0]
//
//  A byte that gives no result leaves the parser ready for the next byte. A
//  byte that completes an acted message passes the stack command register,
//  the stack unit (with its comparator slot scan, one slot per cycle, for note
//  off and key pressure), the result state and the output register.
//  Reset is synchronous on aresetn; no clearing pass is needed.
//  s_ready stays low while an item is in work and while its result waits for
//  the output register, which a stalled m_ready keeps occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_note_stack_pitch_control
    import nsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_midi_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_pitch_index,
    output logic [6:0]       m_on_time_index,

    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_EMIT
    } state_t;

    state_t       state_reg;

    // Configuration
    logic         midi_enable_reg;
    logic [3:0]   midi_channel_reg;
    logic [7:0]   max_pitch_reg;
    logic [6:0]   max_on_time_reg;

    // Parser state
    logic [7:0]   running_status_reg;
    logic         second_byte_due_reg;
    logic [6:0]   first_data_byte_reg;
    logic [13:0]  bend_reg;

    stk_cmd_t     cmd_reg;
    stk_stat_t    stk_stat;

    logic         m_valid_reg;
    logic [7:0]   pitch_reg;
    logic [6:0]   on_time_reg;

    logic         accept;
    logic         is_status;
    logic [6:0]   data;
    logic [3:0]   kind;
    logic         one_byte;
    logic         complete;
    logic         chan_ok;
    logic         kind_ok;
    logic [6:0]   d1;
    stk_op_t      op_dec;
    logic [7:0]   pitch_raw;
    logic [7:0]   pitch_clamp;
    logic [6:0]   on_time_clamp;

    assign s_ready         = (state_reg == ST_IDLE);
    assign accept          = s_valid && s_ready;
    assign m_valid         = m_valid_reg;
    assign m_pitch_index   = pitch_reg;
    assign m_on_time_index = on_time_reg;

    // Byte classification against the running status
    always_comb begin
        is_status = s_midi_byte[7];
        data      = s_midi_byte[6:0];
        kind      = running_status_reg[7:4];
        one_byte  = (kind == KIND_PROG) || (kind == KIND_CHAN_PRESS) ||
                    (running_status_reg == SYS_SONG_SEL) ||
                    (running_status_reg == SYS_UNDEF_F5);
        complete  = !is_status && (one_byte || second_byte_due_reg);
        chan_ok   = (running_status_reg[3:0] == midi_channel_reg);
        d1        = one_byte ? 7'd0 : first_data_byte_reg;
        kind_ok   = 1'b1;
        case (kind)
            KIND_NOTE_OFF:   op_dec = OP_REMOVE;
            KIND_NOTE_ON:    op_dec = (data == 7'd0) ? OP_REMOVE : OP_PUSH;
            KIND_KEY_PRESS:  op_dec = OP_PRESSURE;
            KIND_CHAN_PRESS: op_dec = OP_CHAN_PRESS;
            KIND_BEND:       op_dec = OP_NONE;
            default: begin
                op_dec  = OP_NONE;
                kind_ok = 1'b0;
            end
        endcase
    end

    // Result: top key shifted by the bend, then both fields clamped
    always_comb begin
        pitch_raw     = {1'b0, stk_stat.top_key} + PITCH_OFFSET - {2'b00, bend_reg[13:8]};
        pitch_clamp   = (pitch_raw > max_pitch_reg) ? max_pitch_reg : pitch_raw;
        on_time_clamp = (stk_stat.top_vel > max_on_time_reg) ? max_on_time_reg
                                                             : stk_stat.top_vel;
    end

    // Stack and scan unit
    nsp_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd_reg),
        .stat    (stk_stat)
    );

    // Control, parser state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            midi_enable_reg     <= 1'b1;
            midi_channel_reg    <= 4'd0;
            max_pitch_reg       <= 8'd127;
            max_on_time_reg     <= 7'd127;
            running_status_reg  <= 8'd0;
            second_byte_due_reg <= 1'b0;
            first_data_byte_reg <= 7'd0;
            bend_reg            <= BEND_CENTRE;
            cmd_reg             <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            // one-cycle command for a complete message on our channel
            cmd_reg.valid <= accept && midi_enable_reg && complete && chan_ok && kind_ok;
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_wen) begin
                case (cfg_index)
                    REG_MIDI_ENABLE:  midi_enable_reg  <= cfg_wdata[0];
                    REG_MIDI_CHANNEL: midi_channel_reg <= cfg_wdata[3:0];
                    REG_MAX_PITCH:    max_pitch_reg    <= cfg_wdata;
                    REG_MAX_ON_TIME:  max_on_time_reg  <= cfg_wdata[6:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept && midi_enable_reg) begin
                        if (is_status) begin
                            running_status_reg <= s_midi_byte;
                            if (s_midi_byte >= SYS_TUNE_REQ) begin
                                first_data_byte_reg <= 7'd0;
                            end
                        end else if (one_byte) begin
                            first_data_byte_reg <= 7'd0;
                        end else if (!second_byte_due_reg) begin
                            first_data_byte_reg <= data;
                            second_byte_due_reg <= 1'b1;
                        end else begin
                            second_byte_due_reg <= 1'b0;
                        end

                        // complete message on our channel
                        if (complete && chan_ok && kind_ok) begin
                            cmd_reg.op    <= op_dec;
                            cmd_reg.key   <= d1;
                            cmd_reg.vel   <= data;
                            if (kind == KIND_BEND) begin
                                bend_reg <= {data, d1};
                            end
                            state_reg <= ST_BUSY;
                        end
                    end
                end
                ST_BUSY: begin
                    if (stk_stat.done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        pitch_reg   <= pitch_clamp;
                        on_time_reg <= on_time_clamp;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Stack completion always leads to the result stage
    a_busy_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUSY && stk_stat.done) |=> state_reg == ST_EMIT)
        else $error("stack completion not followed by result stage");

    // In manual mode an accepted byte starts no work
    a_manual_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !midi_enable_reg) |=> (state_reg == ST_IDLE && !cmd_reg.valid))
        else $error("byte processed in manual mode");
`endif

endmodule

`default_nettype wire
